// ===== design/tbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbe_pkg: shared definitions for the timestamp blob encoder
// Field widths, word types, rounding constants and the queue entry format.
// ----------------------------------------------------------------------------
package tbe_pkg;

  // Input field widths.
  localparam int SECS_W = 44;
  localparam int NS_W   = 30;
  localparam int TYPE_W = 3;

  // Largest number of whole-seconds bytes sent after the header.
  localparam int SECONDS_BYTES = 5;

  // Upper part of the seconds value (seconds >> 4), padded to whole bytes.
  localparam int HI_W          = SECS_W - 4;
  localparam int HI_BYTES      = (HI_W + 7) / 8;
  localparam int HI_PAD_BYTES  = (SECONDS_BYTES > HI_BYTES) ? SECONDS_BYTES : HI_BYTES;
  localparam int HI_PAD_W      = 8 * HI_PAD_BYTES;

  // Longest run: header, marker, seconds bytes and two fraction bytes.
  localparam int MAX_BYTES = 4 + SECONDS_BYTES;
  localparam int TOTAL_W   = $clog2(MAX_BYTES + 1);
  localparam int POS_W     = $clog2(MAX_BYTES);
  localparam int NB_W      = $clog2(SECONDS_BYTES + 1);
  localparam int LEN_W     = 4;

  // Reset value of the blob type code.
  localparam logic [TYPE_W-1:0] TYPE_RESET = 3'd5;

  // Header flag bit.
  localparam logic [7:0] HDR_FLAG = 8'h80;

  // Nanosecond range check.
  localparam logic [NS_W-1:0] NS_LIMIT = 30'd999999999;

  // Exact divide by five: q = (ns * DIV5_MUL) >> DIV5_SHIFT for ns below 2^32.
  localparam int              Q5_W       = 28;
  localparam logic [31:0]     DIV5_MUL   = 32'hCCCC_CCCD;
  localparam int              DIV5_SHIFT = 34;
  localparam int              P5_W       = NS_W + 32;

  // Rounding to 1/4096 s: (q * 8 + 195312) / 390625, done as an exact
  // reciprocal multiply valid for any numerator below 2^31.
  localparam int              X_W        = 31;
  localparam logic [X_W-1:0]  ROUND_HALF = 31'd195312;
  localparam logic [31:0]     RND_MUL    = 32'd2882303762;
  localparam int              RND_SHIFT  = 50;
  localparam int              Q2_W       = 13;
  localparam int              P2_W       = X_W + 32;

  // Queue between the front and back parts.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Input word.
  typedef struct packed {
    logic [SECS_W-1:0] seconds;
    logic [NS_W-1:0]   nanoseconds;
    logic              has_marker;
    logic [7:0]        marker_value;
  } tbe_in_t;

  // Output word.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       error;
  } tbe_out_t;

  // One queued blob: its bytes in send order, their count and the error flag.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [TOTAL_W-1:0]        total;
    logic                      err;
  } tbe_desc_t;

  // Queue status seen by both parts.
  typedef struct packed {
    logic               empty;
    logic [FIFO_CW-1:0] level;
  } tbe_fifo_stat_t;

endpackage

// ===== design/tbe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbe_front: input classification and blob assembly
// Checks each input word, sizes the seconds field, rounds the fraction and
// writes the finished byte list into the queue the cycle after acceptance.
// ----------------------------------------------------------------------------
module tbe_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tbe_pkg::tbe_in_t              in_data,
  input  logic [tbe_pkg::TYPE_W-1:0]    type_code,
  input  tbe_pkg::tbe_fifo_stat_t       fifo_stat,
  output logic                          push,
  output tbe_pkg::tbe_desc_t            push_desc
);
  import tbe_pkg::*;

  logic                accept;
  logic [FIFO_CW:0]    committed;
  logic                err_in;
  logic [NB_W-1:0]     nb_in;
  logic [HI_PAD_W-1:0] hi_in;
  logic [P5_W-1:0]     prod5;

  logic                v1_r;
  logic                err1_r;
  logic                mark1_r;
  logic [7:0]          mval1_r;
  logic [HI_PAD_W-1:0] hi1_r;
  logic [3:0]          nib1_r;
  logic [NB_W-1:0]     nb1_r;
  logic [Q5_W-1:0]     q5_1_r;

  logic [X_W-1:0]      x2;
  logic [P2_W-1:0]     prod2;
  logic [Q2_W-1:0]     q2;
  logic [15:0]         frac;
  logic [LEN_W-1:0]    len;
  logic [7:0]          hdr;

  // Words in the stage register plus words queued must leave a free slot.
  assign committed = {1'b0, fifo_stat.level} + {{FIFO_CW{1'b0}}, v1_r};
  assign in_stall  = committed >= (FIFO_CW + 1)'(FIFO_DEPTH);
  assign accept    = in_valid && !in_stall;

  // Rejection check and seconds byte count on the incoming word.
  always_comb begin
    err_in = (in_data.seconds == '0) || (in_data.nanoseconds > NS_LIMIT);
    hi_in  = HI_PAD_W'(in_data.seconds[SECS_W-1:4]);
    nb_in  = '0;
    for (int b = 0; b < HI_BYTES; b++) begin
      if (hi_in[8*b +: 8] != 8'h00) begin
        nb_in = (b + 1 > SECONDS_BYTES) ? NB_W'(SECONDS_BYTES) : NB_W'(b + 1);
      end
    end
  end

  // Nanoseconds divided by five.
  assign prod5 = P5_W'(in_data.nanoseconds) * P5_W'(DIV5_MUL);

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      err1_r  <= err_in;
      mark1_r <= in_data.has_marker;
      mval1_r <= in_data.marker_value;
      hi1_r   <= hi_in;
      nib1_r  <= in_data.seconds[3:0];
      nb1_r   <= nb_in;
      q5_1_r  <= prod5[DIV5_SHIFT +: Q5_W];
    end
  end

  // Round to units of 1/4096 s and add the low seconds nibble.
  assign x2    = X_W'({q5_1_r, 3'b000}) + ROUND_HALF;
  assign prod2 = P2_W'(x2) * P2_W'(RND_MUL);
  assign q2    = prod2[RND_SHIFT +: Q2_W];
  assign frac  = {nib1_r, 12'h000} + 16'(q2);

  // Header byte: flag, blob length and type code.
  assign len = LEN_W'(nb1_r) + LEN_W'(2) + LEN_W'(mark1_r);
  assign hdr = HDR_FLAG | {1'b0, len, 3'b000} | 8'(type_code);

  // Lay out the bytes of the run in send order.
  always_comb begin : p_assemble
    int j;
    j         = 0;
    push_desc = '0;
    if (err1_r) begin
      push_desc.total = TOTAL_W'(1);
      push_desc.err   = 1'b1;
    end else begin
      push_desc.total = TOTAL_W'(len) + TOTAL_W'(1);
      push_desc.err   = 1'b0;
      for (int k = 0; k < MAX_BYTES; k++) begin
        j = k - 1 - int'(mark1_r);
        if (k == 0) begin
          push_desc.bytes[k] = hdr;
        end else if (mark1_r && k == 1) begin
          push_desc.bytes[k] = mval1_r;
        end else if (j == int'(nb1_r)) begin
          push_desc.bytes[k] = frac[15:8];
        end else if (j == int'(nb1_r) + 1) begin
          push_desc.bytes[k] = frac[7:0];
        end else begin
          // Seconds bytes, most significant first.
          for (int b = 0; b < SECONDS_BYTES; b++) begin
            if (j >= 0 && j == int'(nb1_r) - 1 - b) begin
              push_desc.bytes[k] = hi1_r[8*b +: 8];
            end
          end
        end
      end
    end
  end

  assign push = v1_r;

endmodule

// ===== design/tbe_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbe_fifo: blob queue
// A short first-in first-out queue of assembled blobs between the two parts.
// ----------------------------------------------------------------------------
module tbe_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  tbe_pkg::tbe_desc_t      push_desc,
  input  logic                    pop,
  output tbe_pkg::tbe_desc_t      head,
  output tbe_pkg::tbe_fifo_stat_t stat
);
  import tbe_pkg::*;

  tbe_desc_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_nxt;
  logic [FIFO_CW-1:0] count_r;
  logic [FIFO_CW-1:0] count_nxt;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + FIFO_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + FIFO_CW'(push) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.level = count_r;

endmodule

// ===== design/tbe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbe_back: byte serialiser
// Sends the blob at the head of the queue one byte per cycle unless stalled
// through the output register and releases it after its final byte.
// ----------------------------------------------------------------------------
module tbe_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tbe_pkg::tbe_desc_t      head,
  input  tbe_pkg::tbe_fifo_stat_t fifo_stat,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output tbe_pkg::tbe_out_t       out_data
);
  import tbe_pkg::*;

  logic             out_valid_r;
  logic             out_valid_nxt;
  tbe_out_t         out_data_r;
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic             load_ok;
  logic             emit;
  logic             is_last;

  // The output register may take a new word when empty or being drained.
  assign load_ok = !out_valid_r || !out_stall;
  assign emit    = load_ok && !fifo_stat.empty;
  assign is_last = (TOTAL_W'(pos_r) + TOTAL_W'(1)) == head.total;
  assign pop     = emit && is_last;

  // Byte position within the current blob.
  always_comb begin
    if (pop) begin
      pos_nxt = '0;
    end else if (emit) begin
      pos_nxt = pos_r + POS_W'(1);
    end else begin
      pos_nxt = pos_r;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (load_ok) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.out_byte <= head.bytes[pos_r];
      out_data_r.last     <= is_last;
      out_data_r.error    <= head.err;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/timestamp_blob_encoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_blob_encoder_unit: timestamp blob encoder, top level
// Encodes seconds, nanoseconds and an optional marker as a byte stream blob.
//
//   Channel  Direction  Handshake           Word
//   in_      input      in_valid/in_stall   tbe_in_t (seconds, ns, marker)
//   out_     output     out_valid/out_stall tbe_out_t (byte, last, error)
//   cfg_     input      cfg_valid/cfg_ready 3-bit blob type code
//
// Each word yields 1 + marker + n output bytes (3 to 9), or one error byte,
// sent one per cycle by the serialiser; that byte rate sets the throughput.
// Bytes reach the output register through the stage register and the queue.
// Reset (rst_n low at a clock edge) empties the queue and sets the type code
// to 5. in_stall rises once the queued blobs and the staged word number four;
// out_stall holds the output register and, through the queue, the input.
// ----------------------------------------------------------------------------
module timestamp_blob_encoder_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  tbe_pkg::tbe_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output tbe_pkg::tbe_out_t          out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tbe_pkg::TYPE_W-1:0] cfg_data
);
  import tbe_pkg::*;

  logic [TYPE_W-1:0] type_code_r;
  logic [TYPE_W-1:0] type_code_nxt;
  logic              push;
  logic              pop;
  tbe_desc_t         push_desc;
  tbe_desc_t         head;
  tbe_fifo_stat_t    fifo_stat;

  // Type code register; writes are always taken.
  assign cfg_ready     = 1'b1;
  assign type_code_nxt = (cfg_valid && cfg_ready) ? cfg_data : type_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_code_r <= TYPE_RESET;
    end else begin
      type_code_r <= type_code_nxt;
    end
  end

  tbe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .type_code (type_code_r),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_desc (push_desc)
  );

  tbe_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .stat      (fifo_stat)
  );

  tbe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .fifo_stat (fifo_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // The queue never overflows: admission keeps a slot for the staged word.
  assert property (@(posedge clk) disable iff (!rst_n)
    fifo_stat.level <= FIFO_CW'(FIFO_DEPTH))
    else $error("blob queue overfilled");

  // No push into a full queue.
  assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (fifo_stat.level != FIFO_CW'(FIFO_DEPTH)) || pop)
    else $error("push into full blob queue");

  // An error word is a whole run of its own with a zero byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.error) |-> (out_data.last && out_data.out_byte == 8'h00))
    else $error("error word malformed");

  // Release from the queue only while it holds a blob.
  assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !fifo_stat.empty)
    else $error("pop from empty blob queue");

endmodule

// ===== bench/tbe_blob_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbe_blob_checker: blob predictor and byte stream checker
// Watches the input, result and type code channels of the encoder. It works
// out the bytes that each accepted word must produce and compares every
// accepted result word, field by field, with the oldest byte still awaited.
// ----------------------------------------------------------------------------
module tbe_blob_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  tbe_pkg::tbe_in_t           in_data,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  tbe_pkg::tbe_out_t          out_data,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [tbe_pkg::TYPE_W-1:0] cfg_data,
  output int                         mismatches,
  output int                         pending
);
  import tbe_pkg::*;

  localparam logic [TYPE_W-1:0] DEFAULT_TYPE = 3'd5;
  localparam logic [7:0]        HDR_BIT      = 8'h80;
  localparam logic [29:0]       NS_MAX       = 30'd999999999;
  localparam longint unsigned   HALF_TICK    = 195312;
  localparam longint unsigned   TICK_DIV     = 390625;
  localparam int                MAX_RUN      = 4 + SECONDS_BYTES;
  localparam int                PRINT_LIMIT  = 40;

  logic [TYPE_W-1:0] type_code;
  tbe_out_t          expected_bytes[$];

  // One line per fault; the count goes on even once printing has stopped.
  task automatic report_fault(input string msg);
    if (mismatches < PRINT_LIMIT) begin
      $display("[%0t ns] %s", $realtime, msg);
    end
    mismatches++;
  endtask

  // Appends the expected result words of one input word to the queue.
  function automatic void encode_blob(input tbe_in_t w, input logic [TYPE_W-1:0] code);
    logic [SECS_W-5:0] upper;
    logic [SECS_W-5:0] rest;
    longint unsigned   ticks;
    logic [15:0]       frac;
    logic [3:0]        len;
    logic [7:0]        blob [MAX_RUN];
    int                n;
    int                count;
    if (w.seconds == '0 || w.nanoseconds > NS_MAX) begin
      expected_bytes.push_back('{out_byte: 8'h00, last: 1'b1, error: 1'b1});
      return;
    end
    // Fewest bytes that hold the upper seconds, within the cap.
    upper = w.seconds[SECS_W-1:4];
    rest  = upper;
    n     = 2;
    while (n < 2 + SECONDS_BYTES && rest != '0) begin
      n++;
      rest = rest >> 8;
    end
    // Nanoseconds rounded to 1/4096 s; a carry runs into the nibble and wraps.
    ticks = (longint'(w.nanoseconds) / 5 * 8 + HALF_TICK) / TICK_DIV;
    frac  = 16'(longint'(w.seconds[3:0]) * 4096 + ticks);
    len   = 4'(n + w.has_marker);
    count = 0;
    blob[count] = HDR_BIT | {1'b0, len, code};
    count++;
    if (w.has_marker) begin
      blob[count] = w.marker_value;
      count++;
    end
    for (int i = 0; i < n - 2; i++) begin
      blob[count] = 8'(upper >> (8 * (n - 3 - i)));
      count++;
    end
    blob[count] = frac[15:8];
    count++;
    blob[count] = frac[7:0];
    count++;
    for (int i = 0; i < count; i++) begin
      expected_bytes.push_back('{out_byte: blob[i], last: 1'(i == count - 1), error: 1'b0});
    end
  endfunction

  // Handshakes are sampled at the clock edge, before the block updates.
  always @(posedge clk) begin
    tbe_out_t want;
    if (!rst_n) begin
      expected_bytes.delete();
      type_code = DEFAULT_TYPE;
    end else begin
      if (cfg_valid && cfg_ready) begin
        type_code = cfg_data;
      end
      if (in_valid && !in_stall) begin
        encode_blob(in_data, type_code);
      end
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          report_fault($sformatf("unexpected word: byte %02h last %b error %b",
                                 out_data.out_byte, out_data.last, out_data.error));
        end else begin
          want = expected_bytes.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            report_fault($sformatf("out_byte: got %02h, want %02h",
                                   out_data.out_byte, want.out_byte));
          end
          if (out_data.last !== want.last) begin
            report_fault($sformatf("last: got %b, want %b", out_data.last, want.last));
          end
          if (out_data.error !== want.error) begin
            report_fault($sformatf("error: got %b, want %b", out_data.error, want.error));
          end
        end
      end
    end
    pending <= expected_bytes.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: timestamp blob encoder test
// Drives directed and random timestamp words through the encoder under
// several idle and stall patterns and type codes, including a long hold on
// the result side, and leaves the checking to the blob checker.
// ----------------------------------------------------------------------------
module testbench;
  import tbe_pkg::*;

  localparam int RESET_CYCLES = 7;
  localparam int HOLD_CYCLES  = 200;
  localparam int TAIL_CYCLES  = 20;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_WORDS  = 110;
  localparam int PRESS_WORDS  = 30;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  tbe_in_t           in_data   = '0;
  logic              out_stall = 1'b0;
  logic              cfg_valid = 1'b0;
  logic [TYPE_W-1:0] cfg_data  = '0;
  logic              in_stall;
  logic              out_valid;
  tbe_out_t          out_data;
  logic              cfg_ready;
  int                mismatches;
  int                pending;
  int                idle_pct  = 0;
  int                stall_pct = 0;
  bit                hold_req  = 1'b0;
  bit                hold_done = 1'b0;
  int                hold_left = 0;
  int                cycles    = 0;

  always #6 clk = ~clk;

  timestamp_blob_encoder_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  tbe_blob_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: random stalls, or a single long hold once requested.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic tbe_in_t make_word(input logic [SECS_W-1:0] secs,
                                        input logic [NS_W-1:0] ns,
                                        input logic mark,
                                        input logic [7:0] mval);
    tbe_in_t w;
    w.seconds      = secs;
    w.nanoseconds  = ns;
    w.has_marker   = mark;
    w.marker_value = mval;
    return w;
  endfunction

  // Mostly well-formed timestamps of every length, with some rejects and
  // some nanosecond values close enough to one second to round up.
  function automatic tbe_in_t random_word();
    tbe_in_t     w;
    logic [63:0] upper;
    logic [3:0]  nibble;
    int          width;
    int          pick;
    pick           = int'($urandom_range(99));
    w.has_marker   = 1'($urandom_range(1));
    w.marker_value = 8'($urandom_range(255));
    if (pick < 4) begin
      w.seconds     = '0;
      w.nanoseconds = NS_W'($urandom);
    end else if (pick < 8) begin
      w.seconds     = SECS_W'({$urandom, $urandom});
      w.nanoseconds = NS_W'($urandom_range(30'h3FFF_FFFF, 1000000000));
      if (w.seconds == '0) begin
        w.seconds = SECS_W'(1);
      end
    end else begin
      width  = int'($urandom_range(SECS_W - 4));
      upper  = {$urandom, $urandom} & ((64'd1 << width) - 64'd1);
      nibble = (upper == '0) ? 4'($urandom_range(15, 1)) : 4'($urandom_range(15));
      w.seconds = {upper[SECS_W-5:0], nibble};
      if (pick < 22) begin
        w.nanoseconds = NS_W'($urandom_range(999999999, 999877000));
      end else begin
        w.nanoseconds = NS_W'($urandom_range(999999999, 0));
      end
    end
    return w;
  endfunction

  // Offers one word, with a random gap first, and returns once it is taken.
  task automatic send_word(input tbe_in_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  // Stops offering and waits until every awaited byte has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
  endtask

  // Writes the type code with the block idle, then sets the next idling mix.
  task automatic next_phase(input logic [TYPE_W-1:0] code, input int idle, input int stall);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= code;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    idle_pct  = idle;
    stall_pct = stall;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under the reset type code.
    send_word(make_word(44'd1, 30'd0, 1'b0, 8'hA5));
    send_word(make_word(44'd0, 30'd0, 1'b0, 8'h00));
    send_word(make_word(44'd0, 30'd999999999, 1'b1, 8'h11));
    send_word(make_word(44'd77, 30'd1000000000, 1'b0, 8'h00));
    send_word(make_word(44'hFFF_FFFF_FFFF, 30'h3FFF_FFFF, 1'b1, 8'hFF));
    send_word(make_word(44'hFFF_FFFF_FFFF, 30'd999999999, 1'b1, 8'hFF));
    send_word(make_word(44'hFFF_FFFF_FFFF, 30'd0, 1'b0, 8'h00));
    send_word(make_word(44'd16, 30'd999999999, 1'b0, 8'h3C));
    send_word(make_word(44'd15, 30'd999877930, 1'b1, 8'h00));
    send_word(make_word(44'd15, 30'd999877929, 1'b0, 8'hFF));
    send_word(make_word(44'd5, 30'd122070, 1'b0, 8'h00));
    send_word(make_word(44'd5, 30'd122071, 1'b1, 8'h5A));
    for (int k = 0; k < SECONDS_BYTES; k++) begin
      send_word(make_word(44'd16 << (8 * k), 30'd500000000, k[0], 8'(k)));
    end
    send_word(make_word(44'hAAA_AAAA_AAAA, 30'h1555_5555, 1'b1, 8'h55));
    send_word(make_word(44'h555_5555_5555, 30'h2AAA_AAAA, 1'b0, 8'hAA));

    // Random words under several type codes and idling mixes.
    next_phase(3'd0, 0, 0);
    repeat (PHASE_WORDS) send_word(random_word());
    next_phase(3'd7, 75, 0);
    repeat (PHASE_WORDS) send_word(random_word());
    next_phase(3'($urandom_range(7)), 0, 75);
    repeat (PHASE_WORDS) send_word(random_word());
    next_phase(3'($urandom_range(7)), 22, 22);
    repeat (PHASE_WORDS) send_word(random_word());

    // Long hold on the result side while words keep coming, to fill the block.
    next_phase(3'd3, 0, 0);
    hold_req = 1'b1;
    repeat (PRESS_WORDS) send_word(random_word());

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
